// ===== rtl/pss_pkg.sv =====
`timescale 1ns / 1ps

package pss_pkg;

  localparam int MAX_PROBES = 1048576;
  localparam int MAX_SET    = 64;
  localparam int IDX_W      = 20;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DISTANCE   = 8'd0,
    CFG_OPTIMAL_SIZE   = 8'd1,
    CFG_MAX_SIZE       = 8'd2,
    CFG_SHUFFLE_OFFSET = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] probe_location;
    logic [7:0]  chromosome_code;
    logic        last_probe;
  } pss_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  set_start;
    logic [SIZE_W-1:0] set_size;
    logic              final_set;
    logic              run_end;
  } pss_out_t;

  typedef struct packed {
    logic [1:0] push_cnt;
  } pss_fifo_ctl_t;

endpackage

// ===== rtl/probe_set_segmenter.sv =====
`timescale 1ns / 1ps

// Probe set segmenter: takes one sorted probe per cycle on in_valid/in_ready and
// returns each finished set as a start index and size on out_valid/out_ready. An
// item is held in the input register, where the cut decision is made and the
// set state advances, and its zero, one or two results are then written into a
// four-entry result queue whose head drives the out_ port, so the first result
// shows on out_ as soon as the queue has been written. In steady flow one item
// enters every cycle; in_ready drops only while the result queue holds more than
// two untaken results. A set is reported when the probe after it arrives, or at
// once when last_probe is set; run_end marks the last result of each item.
// Configuration writes take effect for the next item processed and are always
// ready.
module probe_set_segmenter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pss_pkg::pss_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pss_pkg::pss_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pss_pkg::*;

  localparam logic [IDX_W-1:0]  IDX_MAX = IDX_W'(MAX_PROBES - 1);
  localparam logic [SIZE_W-1:0] SET_MAX = SIZE_W'(MAX_SET);

  function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W:0] v);
    logic [IDX_W-1:0] r;
    if (v > {1'b0, IDX_MAX}) begin
      r = IDX_MAX;
    end else begin
      r = v[IDX_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [31:0]       max_distance_r;
  logic [SIZE_W-1:0] optimal_size_r;
  logic [SIZE_W-1:0] max_size_r;
  logic [5:0]        shuffle_offset_r;

  // input register
  logic     in_vld_r;
  pss_in_t  in_item_r;

  // set state
  logic [31:0]       prev_loc_r, prev_loc_nxt;
  logic [7:0]        prev_chr_r, prev_chr_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [SIZE_W-1:0] gap_r, gap_nxt;
  logic              shuf_r, shuf_nxt;

  logic              advance;
  logic              room;
  pss_fifo_ctl_t     fifo_ctl;
  pss_out_t          res0, res1;

  logic [SIZE_W-1:0] win;
  logic [SIZE_W-1:0] opt;
  logic              dist_cut;
  logic              cut_set;
  logic              full_set;
  logic [31:0]       loc_step;
  logic [IDX_W-1:0]  start_mid;
  logic [IDX_W-1:0]  idx_span0;
  logic [IDX_W-1:0]  idx_span1;
  logic [SIZE_W-1:0] gap_mid;
  logic [SIZE_W-1:0] gap_inc;
  logic              shuf_new;
  logic              set0;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld_r && room;
  assign in_ready  = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_distance_r   <= 32'd1000;
      optimal_size_r   <= SIZE_W'(4);
      max_size_r       <= SIZE_W'(8);
      shuffle_offset_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_DISTANCE:   max_distance_r   <= cfg_data;
        CFG_OPTIMAL_SIZE:   optimal_size_r   <= cfg_data[SIZE_W-1:0];
        CFG_MAX_SIZE:       max_size_r       <= cfg_data[SIZE_W-1:0];
        CFG_SHUFFLE_OFFSET: shuffle_offset_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_comb begin
    if (max_size_r == '0) begin
      win = SIZE_W'(1);
    end else if (max_size_r > SET_MAX) begin
      win = SET_MAX;
    end else begin
      win = max_size_r;
    end
    if (optimal_size_r == '0) begin
      opt = SIZE_W'(1);
    end else if (optimal_size_r > win) begin
      opt = win;
    end else begin
      opt = optimal_size_r;
    end

    loc_step = in_item_r.probe_location - prev_loc_r;
    dist_cut = (in_item_r.chromosome_code != prev_chr_r) ||
               (in_item_r.probe_location < prev_loc_r) ||
               (loc_step > max_distance_r);
    cut_set  = have_prev_r && (dist_cut || shuf_r);
    full_set = have_prev_r && !cut_set &&
               ({1'b0, idx_r} >= ({1'b0, start_r} + (IDX_W+1)'(win)));
    set0     = cut_set || full_set;

    idx_span0 = idx_r - start_r;
    if (cut_set) begin
      start_mid = idx_r;
    end else if (full_set) begin
      start_mid = sat_idx({1'b0, start_r} + (IDX_W+1)'(opt));
    end else begin
      start_mid = start_r;
    end
    idx_span1 = idx_r - start_mid;

    gap_mid  = (have_prev_r && dist_cut) ? '0 : gap_r;
    gap_inc  = (gap_mid != '1) ? gap_mid + SIZE_W'(1) : gap_mid;
    shuf_new = (shuffle_offset_r != '0) &&
               (SIZE_W'(shuffle_offset_r) < optimal_size_r) &&
               (gap_inc == SIZE_W'(shuffle_offset_r));

    res0.set_start = start_r;
    res0.set_size  = cut_set ? idx_span0[SIZE_W-1:0] : opt;
    res0.final_set = 1'b0;
    res0.run_end   = !in_item_r.last_probe;

    res1.set_start = start_mid;
    res1.set_size  = idx_span1[SIZE_W-1:0] + SIZE_W'(1);
    res1.final_set = 1'b1;
    res1.run_end   = 1'b1;

    // first pushed item is the settled set when there is one, else the final set
    if (!advance) begin
      fifo_ctl.push_cnt = 2'd0;
    end else begin
      fifo_ctl.push_cnt = 2'(set0) + 2'(in_item_r.last_probe);
    end

    prev_loc_nxt  = prev_loc_r;
    prev_chr_nxt  = prev_chr_r;
    have_prev_nxt = have_prev_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    gap_nxt       = gap_r;
    shuf_nxt      = shuf_r;
    if (advance) begin
      if (in_item_r.last_probe) begin
        prev_loc_nxt  = '0;
        prev_chr_nxt  = '0;
        have_prev_nxt = 1'b0;
        idx_nxt       = '0;
        start_nxt     = '0;
        gap_nxt       = '0;
        shuf_nxt      = 1'b0;
      end else begin
        prev_loc_nxt  = in_item_r.probe_location;
        prev_chr_nxt  = in_item_r.chromosome_code;
        have_prev_nxt = 1'b1;
        idx_nxt       = sat_idx({1'b0, idx_r} + (IDX_W+1)'(1));
        start_nxt     = start_mid;
        gap_nxt       = gap_inc;
        shuf_nxt      = shuf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_loc_r  <= '0;
      prev_chr_r  <= '0;
      have_prev_r <= 1'b0;
      idx_r       <= '0;
      start_r     <= '0;
      gap_r       <= '0;
      shuf_r      <= 1'b0;
    end else begin
      prev_loc_r  <= prev_loc_nxt;
      prev_chr_r  <= prev_chr_nxt;
      have_prev_r <= have_prev_nxt;
      idx_r       <= idx_nxt;
      start_r     <= start_nxt;
      gap_r       <= gap_nxt;
      shuf_r      <= shuf_nxt;
    end
  end

  pss_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (fifo_ctl),
    .room       (room),
    .push_data0 (set0 ? res0 : res1),
    .push_data1 (res1),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/pss_out_fifo.sv =====
`timescale 1ns / 1ps

module pss_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pss_pkg::pss_fifo_ctl_t ctl_in,
  output logic                   room,
  input  pss_pkg::pss_out_t      push_data0,
  input  pss_pkg::pss_out_t      push_data1,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pss_pkg::pss_out_t      out_data
);
  import pss_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  pss_out_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for two more items, whatever leaves this cycle
  assign room      = (count_r <= (PTR_W+1)'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(ctl_in.push_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + (PTR_W+1)'(ctl_in.push_cnt) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_data0;
    end
    if (ctl_in.push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push_data1;
    end
  end

endmodule
